>>> design/recursive_mutex_fifo_waiters_macros.svh
// assertion macros for the recursive mutex with fifo wait queue
`ifndef RECURSIVE_MUTEX_FIFO_WAITERS_MACROS_SVH
`define RECURSIVE_MUTEX_FIFO_WAITERS_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define RMFW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmfw assertion failed");
// next-cycle implication, disabled during reset
`define RMFW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmfw assertion failed");
`else
`define RMFW_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RMFW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/rmfw_pkg.sv
// shared types and constants for the recursive mutex with fifo wait queue
`default_nettype none
package rmfw_pkg;

    // fixed field widths
    localparam int TASK_W   = 4;
    localparam int STATUS_W = 3;
    localparam int LEVEL_W  = 8;

    // configuration defaults
    localparam int TASK_COUNT     = 16;
    localparam int WAIT_DEPTH_DEF = 16;
    localparam int COUNT_MAX_DEF  = 255;

    // opcodes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REGRANTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HELD       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FREED_WOKE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd7;

    // request word
    typedef struct packed {
        logic              opcode;
        logic [TASK_W-1:0] task_id;
    } req_t;

    // result word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wake_valid;
        logic [TASK_W-1:0]   wake_task;
        logic [LEVEL_W-1:0]  hold_level;
    } res_t;

endpackage
`default_nettype wire

>>> design/recursive_mutex_fifo_waiters.sv
// Recursive lock with fifo wait queue: owner, hold count, and waiters in a memory.
// Flow: an accepted word is registered and busy rises; the decision is computed while busy
// is high, the result register loads at the end of that cycle and done strobes for one cycle.
// Start is ignored while busy is high, so no new word is taken until the last one is decided;
// busy is high while the registered wait queue head read returns. The receiver cannot stall.
// Reset: owner, hold count and queue pointers clear at once; queue memory is not cleared.
`default_nettype none
`include "recursive_mutex_fifo_waiters_macros.svh"
module recursive_mutex_fifo_waiters
    import rmfw_pkg::*;
#(
    parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
    parameter int COUNT_MAX  = COUNT_MAX_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      done,
    output res_t      result
);

    localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
    localparam int CNT_W  = $clog2(COUNT_MAX + 1);

    // control and lock state
    logic              busy_reg;
    logic              done_reg;
    req_t              cur_reg;
    res_t              result_reg, result_next;
    logic              owner_valid_reg, owner_valid_next;
    logic [TASK_W-1:0] owner_reg, owner_next;
    logic [CNT_W-1:0]  hold_reg, hold_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // wait queue memory
    logic [TASK_W-1:0] wait_mem [WAIT_DEPTH];
    logic [TASK_W-1:0] head_data_reg;
    logic              mem_we;

    logic accept;
    logic in_range;

    assign accept   = start && !busy_reg;
    assign in_range = 32'(cur_reg.task_id) < TASK_COUNT;

    // queue memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wait_mem[tail_reg] <= cur_reg.task_id;
        end
        head_data_reg <= wait_mem[head_reg];
    end

    // request capture, no reset needed on payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= req;
        end
        result_reg <= result_next;
    end

    // lock decision for the captured word
    always_comb
    begin
        owner_valid_next      = owner_valid_reg;
        owner_next            = owner_reg;
        hold_next             = hold_reg;
        head_next             = head_reg;
        tail_next             = tail_reg;
        fill_next             = fill_reg;
        mem_we                = 1'b0;
        result_next           = result_reg;
        result_next.status    = ST_NOT_OWNER;
        result_next.wake_valid = 1'b0;
        result_next.wake_task = '0;

        if (busy_reg)
        begin
            if (!in_range)
            begin
                result_next.status = ST_NOT_OWNER;
            end
            else if (cur_reg.opcode == OP_ACQUIRE)
            begin
                if (!owner_valid_reg)
                begin
                    owner_valid_next   = 1'b1;
                    owner_next         = cur_reg.task_id;
                    hold_next          = CNT_W'(1);
                    result_next.status = ST_GRANTED;
                end
                else if (owner_reg == cur_reg.task_id)
                begin
                    if (hold_reg >= CNT_W'(COUNT_MAX))
                    begin
                        result_next.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        hold_next          = hold_reg + CNT_W'(1);
                        result_next.status = ST_REGRANTED;
                    end
                end
                else if (fill_reg >= FILL_W'(WAIT_DEPTH))
                begin
                    result_next.status = ST_OVERFLOW;
                end
                else
                begin
                    mem_we             = 1'b1;
                    tail_next          = (tail_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                         '0 : tail_reg + PTR_W'(1);
                    fill_next          = fill_reg + FILL_W'(1);
                    result_next.status = ST_QUEUED;
                end
            end
            else
            begin
                if (!owner_valid_reg || owner_reg != cur_reg.task_id)
                begin
                    result_next.status = ST_NOT_OWNER;
                end
                else
                begin
                    if (hold_reg != '0)
                    begin
                        hold_next = hold_reg - CNT_W'(1);
                    end
                    if (hold_next != '0)
                    begin
                        result_next.status = ST_HELD;
                    end
                    else
                    begin
                        owner_valid_next = 1'b0;
                        owner_next       = '0;
                        if (fill_reg != '0)
                        begin
                            result_next.wake_valid = 1'b1;
                            result_next.wake_task  = head_data_reg;
                            head_next = (head_reg == PTR_W'(WAIT_DEPTH - 1)) ?
                                        '0 : head_reg + PTR_W'(1);
                            fill_next          = fill_reg - FILL_W'(1);
                            result_next.status = ST_FREED_WOKE;
                        end
                        else
                        begin
                            result_next.status = ST_FREED;
                        end
                    end
                end
            end
        end

        // hold level saturates at the field maximum
        if (32'(hold_next) > 255)
        begin
            result_next.hold_level = '1;
        end
        else
        begin
            result_next.hold_level = LEVEL_W'(hold_next);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            owner_valid_reg <= 1'b0;
            owner_reg       <= '0;
            hold_reg        <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            fill_reg        <= '0;
        end
        else
        begin
            busy_reg        <= accept;
            done_reg        <= busy_reg;
            owner_valid_reg <= owner_valid_next;
            owner_reg       <= owner_next;
            hold_reg        <= hold_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            fill_reg        <= fill_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `RMFW_ASSERT_NEXT(a_one_result, clk, rst_n, busy_reg, done_reg && !busy_reg)
    `RMFW_ASSERT_NOW(a_wake_status, clk, rst_n, done && result.wake_valid, result.status == ST_FREED_WOKE)
    `RMFW_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_W'(WAIT_DEPTH))
    `RMFW_ASSERT_NOW(a_free_no_hold, clk, rst_n, !owner_valid_reg, hold_reg == '0)

endmodule
`default_nettype wire
